// ===== hdl/mcpf_pkg.sv =====
// Shared types and constants for the MQTT connect packet framer.
`timescale 1ns / 1ps

package mcpf_pkg;

  // Command codes carried by the input item
  typedef enum logic [1:0] {
    OP_CONNECT = 2'd0,
    OP_ID_BYTE = 2'd1,
    OP_PING    = 2'd2,
    OP_UNUSED  = 2'd3
  } opcode_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_ALIVE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLIENT_ID_LEN = 1'd1;

  localparam logic [15:0] KEEP_ALIVE_RST = 16'd60;
  localparam logic [15:0] CLIENT_ID_LEN_RST = 16'd0;

  // Fixed packet bytes
  localparam logic [7:0] CONNECT_TYPE = 8'h10;
  localparam logic [7:0] PING_TYPE = 8'hC0;
  localparam logic [7:0] PING_LEN = 8'h00;
  localparam logic [16:0] VAR_HDR_LEN = 17'd12;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] id_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       packet_end;
    logic       misuse_error;
  } out_item_t;

  // Control from the top level into the header sequencer
  typedef struct packed {
    logic        start;
    logic        step;
    logic [15:0] alive_secs;
    logic [15:0] id_len;
  } hdr_ctl_t;

  // Status from the header sequencer
  typedef struct packed {
    logic [7:0] hdr_byte;
    logic       hdr_end;
    logic       done;
  } hdr_stat_t;

endpackage

// ===== hdl/mqtt_connect_packet_framer_unit.sv =====
// Top level of the MQTT connect / ping packet framer.
//
//   channel | ports                                  | direction
//   input   | in_valid, in_ready, in_data            | item in: opcode, id_byte
//   result  | out_valid, out_ready, out_data         | item out: byte, end, error
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
//
// A connect item yields its type byte, then each header byte produced by the
// header sequencer (1 to 3 varint bytes from its shifted length register, then 12 fixed).
// A ping item yields a type byte and a zero length byte; an id byte item yields one byte.
// Output stalls hold the sequencer; an item is taken only while the block is
// idle and the output register is free or draining.
// Reset is synchronous, active low; no memory sweep follows it.
`timescale 1ns / 1ps

module mqtt_connect_packet_framer_unit
  import mcpf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_HDR  = 3'b010,
    ST_PING = 3'b100
  } state_t;

  state_t      state_r, state_nxt;
  logic [15:0] alive_secs_r, alive_secs_nxt;
  logic [15:0] id_len_r, id_len_nxt;
  logic [15:0] id_left_r, id_left_nxt;
  logic        conn_open_r, conn_open_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;
  logic        out_free;
  logic        in_acc;
  opcode_t     op;
  hdr_ctl_t    hdr_ctl;
  hdr_stat_t   hdr_stat;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign in_acc    = in_valid && in_ready;
  assign op        = opcode_t'(in_data.opcode);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration registers
  always_comb begin
    alive_secs_nxt = alive_secs_r;
    id_len_nxt     = id_len_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_KEEP_ALIVE:    alive_secs_nxt = cfg_data;
        REG_CLIENT_ID_LEN: id_len_nxt     = cfg_data;
        default:           ;
      endcase
    end
  end

  // Header sequencer
  assign hdr_ctl.start      = in_acc && (op == OP_CONNECT);
  assign hdr_ctl.step       = (state_r == ST_HDR) && out_free;
  assign hdr_ctl.alive_secs = alive_secs_r;
  assign hdr_ctl.id_len     = id_len_r;

  mcpf_hdr_seq u_hdr_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (hdr_ctl),
    .stat  (hdr_stat)
  );

  // Control and output register
  always_comb begin
    state_nxt     = state_r;
    id_left_nxt   = id_left_r;
    conn_open_nxt = conn_open_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (op)
            OP_CONNECT: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{packet_byte: CONNECT_TYPE, packet_end: 1'b0,
                                misuse_error: 1'b0};
              id_left_nxt   = id_len_r;
              conn_open_nxt = (id_len_r != '0);
              state_nxt     = ST_HDR;
            end
            OP_ID_BYTE: begin
              out_valid_nxt = 1'b1;
              if (conn_open_r && (id_left_r != '0)) begin
                id_left_nxt   = id_left_r - 16'd1;
                conn_open_nxt = (id_left_r != 16'd1);
                out_data_nxt  = '{packet_byte: in_data.id_byte,
                                  packet_end: (id_left_r == 16'd1),
                                  misuse_error: 1'b0};
              end else begin
                out_data_nxt = '{packet_byte: 8'h00, packet_end: 1'b1,
                                 misuse_error: 1'b1};
              end
            end
            OP_PING: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{packet_byte: PING_TYPE, packet_end: 1'b0,
                                misuse_error: 1'b0};
              id_left_nxt   = '0;
              conn_open_nxt = 1'b0;
              state_nxt     = ST_PING;
            end
            default: ;
          endcase
        end
      end
      ST_HDR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{packet_byte: hdr_stat.hdr_byte,
                            packet_end: hdr_stat.hdr_end, misuse_error: 1'b0};
          if (hdr_stat.done) state_nxt = ST_IDLE;
        end
      end
      ST_PING: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{packet_byte: PING_LEN, packet_end: 1'b1,
                            misuse_error: 1'b0};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      alive_secs_r <= KEEP_ALIVE_RST;
      id_len_r     <= CLIENT_ID_LEN_RST;
      id_left_r    <= '0;
      conn_open_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      alive_secs_r <= alive_secs_nxt;
      id_len_r     <= id_len_nxt;
      id_left_r    <= id_left_nxt;
      conn_open_r  <= conn_open_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== hdl/mcpf_hdr_seq.sv =====
// Header sequencer: varint length bytes from a 17-bit register shifted by seven, then variable header.
`timescale 1ns / 1ps

module mcpf_hdr_seq
  import mcpf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  hdr_ctl_t  ctl,
  output hdr_stat_t stat
);

  localparam logic [3:0] LAST_IDX = 4'd11;

  logic        len_phase_r, len_phase_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] ka_r, ka_nxt;
  logic [15:0] len_r, len_nxt;
  logic        more;

  // Variable header byte at a given position
  function automatic logic [7:0] fixed_byte(input logic [3:0] idx,
                                            input logic [15:0] ka,
                                            input logic [15:0] len);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h00;
      4'd1:    b = 8'h04;
      4'd2:    b = 8'h4D;  // M
      4'd3:    b = 8'h51;  // Q
      4'd4:    b = 8'h54;  // T
      4'd5:    b = 8'h54;  // T
      4'd6:    b = 8'h04;  // protocol level
      4'd7:    b = 8'h02;  // clean session
      4'd8:    b = ka[15:8];
      4'd9:    b = ka[7:0];
      4'd10:   b = len[15:8];
      4'd11:   b = len[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  assign more = |rem_r[16:7];

  // Current byte
  always_comb begin
    if (len_phase_r) begin
      stat.hdr_byte = {more, rem_r[6:0]};
      stat.hdr_end  = 1'b0;
      stat.done     = 1'b0;
    end else begin
      stat.hdr_byte = fixed_byte(idx_r, ka_r, len_r);
      stat.done     = (idx_r == LAST_IDX);
      stat.hdr_end  = (idx_r == LAST_IDX) && (len_r == '0);
    end
  end

  // Sequencing: shift remaining length by seven per varint byte
  always_comb begin
    len_phase_nxt = len_phase_r;
    idx_nxt       = idx_r;
    rem_nxt       = rem_r;
    ka_nxt        = ka_r;
    len_nxt       = len_r;
    if (ctl.start) begin
      len_phase_nxt = 1'b1;
      idx_nxt       = '0;
      rem_nxt       = VAR_HDR_LEN + {1'b0, ctl.id_len};
      ka_nxt        = ctl.alive_secs;
      len_nxt       = ctl.id_len;
    end else if (ctl.step) begin
      if (len_phase_r) begin
        rem_nxt = rem_r >> 7;
        if (!more) begin
          len_phase_nxt = 1'b0;
          idx_nxt       = '0;
        end
      end else if (idx_r != LAST_IDX) begin
        idx_nxt = idx_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_phase_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      len_phase_r <= len_phase_nxt;
      idx_r       <= idx_nxt;
    end
    rem_r <= rem_nxt;
    ka_r  <= ka_nxt;
    len_r <= len_nxt;
  end

endmodule

// ===== hdl/mcpf_checker.sv =====
// Port-level checks for the packet framer, bound to the top level.
`timescale 1ns / 1ps

module mcpf_checker
  import mcpf_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A stalled result item stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // Error items are always end-marked and carry a zero byte
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.misuse_error |->
      out_data.packet_end && (out_data.packet_byte == 8'h00))
    else $error("malformed error item");

  // A connect command starts its packet with the type byte
  a_conn_first: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.opcode == OP_CONNECT) |=>
      out_valid && (out_data.packet_byte == CONNECT_TYPE) && !out_data.packet_end)
    else $error("connect did not open with type byte");

  // A ping command starts with its type byte
  a_ping_first: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.opcode == OP_PING) |=>
      out_valid && (out_data.packet_byte == PING_TYPE) && !out_data.packet_end)
    else $error("ping did not open with type byte");

endmodule

bind mqtt_connect_packet_framer_unit mcpf_checker u_mcpf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
